@@ design/cpc_pkg.sv @@
// Shared types and step codes for the convex prism point clip.
// Used by cpc_cell, convex_prism_point_clip_top and the testbench; no dependencies.
package cpc_pkg;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_vtx;

    // running plane-sign summary passed along the cell row
    typedef struct packed {
        logic all_pos;
        logic all_npos;
    } t_acc;

    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_REF     = 2'd1;
    localparam logic [1:0] REQ_VOXEL   = 2'd2;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    // cell step codes: latch differences, twelve multiplies, idle
    localparam logic [3:0] STEP_LATCH = 4'd0;
    localparam logic [3:0] MUL_AYBZ   = 4'd1;
    localparam logic [3:0] MUL_AZBY   = 4'd2;
    localparam logic [3:0] MUL_AZBX   = 4'd3;
    localparam logic [3:0] MUL_AXBZ   = 4'd4;
    localparam logic [3:0] MUL_AXBY   = 4'd5;
    localparam logic [3:0] MUL_AYBX   = 4'd6;
    localparam logic [3:0] MUL_NXLO   = 4'd7;
    localparam logic [3:0] MUL_NXHI   = 4'd8;
    localparam logic [3:0] MUL_NYLO   = 4'd9;
    localparam logic [3:0] MUL_NYHI   = 4'd10;
    localparam logic [3:0] MUL_NZLO   = 4'd11;
    localparam logic [3:0] MUL_NZHI   = 4'd12;
    localparam logic [3:0] STEP_IDLE  = 4'd15;
    localparam logic [3:0] TAG_NONE   = 4'd0;

    // cycles from start until the last dot product is settled
    localparam int DOT_STEPS = 15;

endpackage

@@ design/convex_prism_point_clip_top.sv @@
// Top level of the convex prism point clip: control, count register and
// the row of cpc_cell plane cells. Uses cpc_pkg and cpc_cell.
//
// A load-vertex item is stored at once and busy stays low. A reference or
// voxel item holds busy while each plane cell
// runs 12 multiplies through its single 35x33 multiplier, then the sign
// summary ripples one cell per cycle down the row. A voxel result appears
// on o_hide_voxel with o_valid high for one cycle as busy falls; the
// receiver cannot stall it. Configure point_count only while idle.
module convex_prism_point_clip_top import cpc_pkg::*; #(
    parameter int MAX_POINTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_req_type,
    input  logic [3:0]  i_vertex_index,
    input  logic [31:0] i_coord_x,
    input  logic [31:0] i_coord_y,
    input  logic [31:0] i_coord_z,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    output logic        o_valid,
    output logic        o_hide_voxel
);

    localparam int NCELL     = MAX_POINTS / 2;
    localparam int LAST_STEP = DOT_STEPS - 1 + NCELL;
    localparam int STEP_W    = $clog2(LAST_STEP + 1);

    logic [4:0]        r_count;
    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic [1:0]        r_req;
    t_vtx              r_point;
    logic              r_ref;
    logic              r_valid;
    logic              r_hide;

    logic       w_accept, w_load, w_inside;
    logic [6:0] w_sat, w_planes, w_pair;
    logic [3:0] w_cell_step;
    t_vtx       w_wdata;
    t_vtx       w_v0  [NCELL];
    t_acc       w_acc [NCELL+1];

    assign w_accept = i_start && !r_busy;
    assign w_load   = w_accept && (i_req_type == REQ_LOAD)
                      && (32'(i_vertex_index) < MAX_POINTS);
    assign w_pair   = {3'b0, i_vertex_index} >> 1;
    assign w_wdata  = '{x: i_coord_x, y: i_coord_y, z: i_coord_z};

    // count saturates at the store depth, odd vertex dropped
    assign w_sat    = ({2'b0, r_count} > 7'(MAX_POINTS)) ? 7'(MAX_POINTS) : {2'b0, r_count};
    assign w_planes = w_sat >> 1;

    assign w_cell_step = (r_busy && (32'(r_step) < DOT_STEPS)) ? r_step[3:0] : STEP_IDLE;

    assign w_acc[0] = '{all_pos: 1'b1, all_npos: 1'b1};

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        t_vtx w_third;
        if (k + 1 < NCELL) begin : g_mid
            assign w_third = (w_planes == 7'(k + 1)) ? w_v0[0] : w_v0[k+1];
        end else begin : g_end
            assign w_third = w_v0[0];
        end
        cpc_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_we0    (w_load && (w_pair == 7'(k)) && !i_vertex_index[0]),
            .i_we1    (w_load && (w_pair == 7'(k)) && i_vertex_index[0]),
            .i_wdata  (w_wdata),
            .i_third  (w_third),
            .i_point  (r_point),
            .i_step   (w_cell_step),
            .i_active (w_planes > 7'(k)),
            .i_acc    (w_acc[k]),
            .o_v0     (w_v0[k]),
            .o_acc    (w_acc[k+1])
        );
    end

    assign w_inside = w_acc[NCELL].all_pos | w_acc[NCELL].all_npos;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req   <= i_req_type;
            r_point <= w_wdata;
        end
        if (r_busy && r_step == STEP_W'(LAST_STEP)) begin
            r_hide <= (w_inside == r_ref);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_busy  <= 1'b0;
            r_step  <= '0;
            r_ref   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(LAST_STEP)) begin
                    r_busy <= 1'b0;
                    if (r_req == REQ_REF) begin
                        r_ref <= w_inside;
                    end else begin
                        r_valid <= 1'b1;
                    end
                end
            end else if (w_accept && (i_req_type == REQ_REF || i_req_type == REQ_VOXEL)) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end
        end
    end

    assign o_busy       = r_busy;
    assign o_valid      = r_valid;
    assign o_hide_voxel = r_hide;

    a_valid_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_busy))
        else $error("result without a test in progress");

    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_busy))
        else $error("result strobe while busy");

    a_req_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && $past(r_busy)) |-> $stable(r_req))
        else $error("request type changed mid test");

    a_load_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req_type == REQ_LOAD) |=> !r_busy)
        else $error("vertex load started a test");

endmodule

@@ design/cpc_cell.sv @@
// One plane cell: holds a vertex pair, evaluates the plane sign with one
// shared multiplier, and folds it into the sign summary, or passes the summary on when inactive. Uses cpc_pkg.
module cpc_cell import cpc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_we0,
    input  logic       i_we1,
    input  t_vtx       i_wdata,
    input  t_vtx       i_third,
    input  t_vtx       i_point,
    input  logic [3:0] i_step,
    input  logic       i_active,
    input  t_acc       i_acc,
    output t_vtx       o_v0,
    output t_acc       o_acc
);

    t_vtx r_v0, r_v1;
    logic signed [32:0] r_ax, r_ay, r_az, r_bx, r_by, r_bz, r_dx, r_dy, r_dz;
    logic signed [66:0] r_nx, r_ny, r_nz;
    logic signed [103:0] r_dot;
    logic signed [67:0] r_prod;
    logic [3:0] r_tag;
    t_acc r_acc;

    logic signed [34:0] w_opa;
    logic signed [32:0] w_opb;
    logic signed [67:0] w_prod;
    logic [103:0] w_lo_ext, w_hi_ext;
    logic w_pos;

    function automatic logic signed [32:0] sub33(input logic [31:0] a, input logic [31:0] b);
        sub33 = $signed({a[31], a}) - $signed({b[31], b});
    endfunction

    function automatic logic signed [34:0] sx35(input logic [32:0] v);
        sx35 = $signed({{2{v[32]}}, v});
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_we0) begin
            r_v0 <= i_wdata;
        end
        if (i_we1) begin
            r_v1 <= i_wdata;
        end
    end

    always_comb begin
        unique case (i_step)
            MUL_AYBZ: begin w_opa = sx35(r_ay); w_opb = r_bz; end
            MUL_AZBY: begin w_opa = sx35(r_az); w_opb = r_by; end
            MUL_AZBX: begin w_opa = sx35(r_az); w_opb = r_bx; end
            MUL_AXBZ: begin w_opa = sx35(r_ax); w_opb = r_bz; end
            MUL_AXBY: begin w_opa = sx35(r_ax); w_opb = r_by; end
            MUL_AYBX: begin w_opa = sx35(r_ay); w_opb = r_bx; end
            // normal split into unsigned low 34 bits and signed high 33 bits
            MUL_NXLO: begin w_opa = $signed({1'b0, r_nx[33:0]}); w_opb = r_dx; end
            MUL_NXHI: begin w_opa = sx35(r_nx[66:34]); w_opb = r_dx; end
            MUL_NYLO: begin w_opa = $signed({1'b0, r_ny[33:0]}); w_opb = r_dy; end
            MUL_NYHI: begin w_opa = sx35(r_ny[66:34]); w_opb = r_dy; end
            MUL_NZLO: begin w_opa = $signed({1'b0, r_nz[33:0]}); w_opb = r_dz; end
            MUL_NZHI: begin w_opa = sx35(r_nz[66:34]); w_opb = r_dz; end
            default:  begin w_opa = '0; w_opb = '0; end
        endcase
    end

    assign w_prod   = w_opa * w_opb;
    assign w_lo_ext = {{36{r_prod[67]}}, r_prod};
    assign w_hi_ext = {{2{r_prod[67]}}, r_prod, 34'b0};
    assign w_pos    = !r_dot[103] && (r_dot != '0);

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        priority if (i_step == STEP_LATCH) begin
            r_ax  <= sub33(r_v1.x, r_v0.x);
            r_ay  <= sub33(r_v1.y, r_v0.y);
            r_az  <= sub33(r_v1.z, r_v0.z);
            r_bx  <= sub33(i_third.x, r_v0.x);
            r_by  <= sub33(i_third.y, r_v0.y);
            r_bz  <= sub33(i_third.z, r_v0.z);
            r_dx  <= sub33(i_point.x, r_v0.x);
            r_dy  <= sub33(i_point.y, r_v0.y);
            r_dz  <= sub33(i_point.z, r_v0.z);
            r_nx  <= '0;
            r_ny  <= '0;
            r_nz  <= '0;
            r_dot <= '0;
        end else begin
            unique case (r_tag)
                MUL_AYBZ: r_nx <= r_nx + r_prod[66:0];
                MUL_AZBY: r_nx <= r_nx - r_prod[66:0];
                MUL_AZBX: r_ny <= r_ny + r_prod[66:0];
                MUL_AXBZ: r_ny <= r_ny - r_prod[66:0];
                MUL_AXBY: r_nz <= r_nz + r_prod[66:0];
                MUL_AYBX: r_nz <= r_nz - r_prod[66:0];
                MUL_NXLO, MUL_NYLO, MUL_NZLO: r_dot <= r_dot + $signed(w_lo_ext);
                MUL_NXHI, MUL_NYHI, MUL_NZHI: r_dot <= r_dot + $signed(w_hi_ext);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= TAG_NONE;
            r_acc <= '0;
        end else begin
            r_tag <= (i_step >= MUL_AYBZ && i_step <= MUL_NZHI) ? i_step : TAG_NONE;
            if (i_active) begin
                r_acc.all_pos  <= i_acc.all_pos & w_pos;
                r_acc.all_npos <= i_acc.all_npos & !w_pos;
            end else begin
                r_acc <= i_acc;
            end
        end
    end

    assign o_v0  = r_v0;
    assign o_acc = r_acc;

endmodule

@@ tb/cpc_checker.sv @@
// Checker for the convex prism point clip: watches accepted items and
// results, predicts hide_voxel and compares. Depends on cpc_pkg.
`timescale 1ns / 100ps

module cpc_checker import cpc_pkg::*; #(
    parameter int MAX_POINTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_req_type,
    input  logic [3:0]  i_vertex_index,
    input  logic [31:0] i_coord_x,
    input  logic [31:0] i_coord_y,
    input  logic [31:0] i_coord_z,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    input  logic        i_valid,
    input  logic        i_hide_voxel,
    output int          o_fail_count,
    output int          o_pending
);

    logic signed [31:0] vx [MAX_POINTS];
    logic signed [31:0] vy [MAX_POINTS];
    logic signed [31:0] vz [MAX_POINTS];
    logic [4:0] count_q;
    logic ref_in_q;
    logic hide_q [$];

    function automatic logic plane_positive(int p, int third, logic signed [31:0] tx,
                                            logic signed [31:0] ty, logic signed [31:0] tz);
        logic signed [127:0] ax, ay, az, bx, by, bz, nx, ny, nz, dx, dy, dz, dot;
        ax = vx[p+1] - vx[p]; ay = vy[p+1] - vy[p]; az = vz[p+1] - vz[p];
        bx = vx[third] - vx[p]; by = vy[third] - vy[p]; bz = vz[third] - vz[p];
        nx = ay * bz - az * by;
        ny = az * bx - ax * bz;
        nz = ax * by - ay * bx;
        dx = tx - vx[p]; dy = ty - vy[p]; dz = tz - vz[p];
        dot = nx * dx + ny * dy + nz * dz;
        return dot > 0;
    endfunction

    function automatic logic prism_inside(logic signed [31:0] tx, logic signed [31:0] ty,
                                          logic signed [31:0] tz);
        int n;
        int third;
        logic first;
        logic pos;
        n = (count_q > MAX_POINTS) ? MAX_POINTS : int'(count_q);
        n = n & ~1;
        first = 1'b0;
        for (int p = 0; p < n; p += 2) begin
            third = (p + 2 == n) ? 0 : p + 2;
            pos = plane_positive(p, third, tx, ty, tz);
            if (p == 0) first = pos;
            else if (pos != first) return 1'b0;
        end
        return 1'b1;
    endfunction

    assign o_pending = hide_q.size();

    always @(posedge i_clk) begin
        logic want;
        if (!i_rst_n) begin
            count_q <= '0;
            ref_in_q <= 1'b0;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) count_q <= i_cfg_wdata;
            if (i_valid) begin
                if (hide_q.size() == 0) begin
                    $error("hide_voxel: expected none, actual %0d", i_hide_voxel);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = hide_q.pop_front();
                    if (want !== i_hide_voxel) begin
                        $error("hide_voxel: expected %0d, actual %0d", want, i_hide_voxel);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_start && !i_busy) begin
                case (i_req_type)
                    REQ_LOAD: if (i_vertex_index < MAX_POINTS) begin
                        vx[i_vertex_index] <= i_coord_x;
                        vy[i_vertex_index] <= i_coord_y;
                        vz[i_vertex_index] <= i_coord_z;
                    end
                    REQ_REF: ref_in_q <= prism_inside(i_coord_x, i_coord_y, i_coord_z);
                    REQ_VOXEL: hide_q.push_back(
                        prism_inside(i_coord_x, i_coord_y, i_coord_z) == ref_in_q);
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ tb/tb.sv @@
// Testbench top for the convex prism point clip: stimulus, configuration
// phases and verdict. Depends on cpc_pkg, cpc_checker and the top level.
`timescale 1ns / 100ps

module tb;
    import cpc_pkg::*;

    localparam int MAX_POINTS = 16;
    localparam int LATENCY = 15 + MAX_POINTS / 2;
    localparam int WATCH_LIMIT = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  req_type = '0;
    logic [3:0]  vertex_index = '0;
    logic [31:0] coord_x = '0, coord_y = '0, coord_z = '0;
    logic        cfg_we = 1'b0;
    logic [4:0]  cfg_wdata = '0;
    logic        valid;
    logic        hide_voxel;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    convex_prism_point_clip_top #(.MAX_POINTS(MAX_POINTS)) dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .o_busy(busy),
        .i_req_type(req_type), .i_vertex_index(vertex_index),
        .i_coord_x(coord_x), .i_coord_y(coord_y), .i_coord_z(coord_z),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .o_valid(valid), .o_hide_voxel(hide_voxel)
    );

    cpc_checker #(.MAX_POINTS(MAX_POINTS)) chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_busy(busy),
        .i_req_type(req_type), .i_vertex_index(vertex_index),
        .i_coord_x(coord_x), .i_coord_y(coord_y), .i_coord_z(coord_z),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_valid(valid), .i_hide_voxel(hide_voxel),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // watchdog on cycles with no accepted item and no result
    always @(posedge clk) begin
        if ((start && !busy) || valid || cfg_we || !rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // drive one item and hold it until accepted
    task automatic send_item(logic [1:0] rt, logic [3:0] idx, logic [31:0] x,
                             logic [31:0] y, logic [31:0] z, logic gaps);
        int gap;
        if (gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req_type <= rt;
        vertex_index <= idx;
        coord_x <= x; coord_y <= y; coord_z <= z;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy) @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_count(logic [4:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 8) << 16;
            2: return -($urandom_range(0, 8) << 16);
            default: return $signed($urandom_range(0, 2000)) - 1000;
        endcase
    endfunction

    // vertex loads and points with random content; every slot is written by then
    task automatic random_phase(int items, logic gaps);
        int r;
        int mode;
        logic [3:0] idx;
        for (int i = 0; i < items; i++) begin
            r = $urandom_range(0, 19);
            mode = $urandom_range(0, 3);
            idx = 4'($urandom);
            if (r < 5)
                send_item(REQ_LOAD, idx, rand_coord(mode), rand_coord(mode),
                          rand_coord(mode), gaps);
            else if (r < 7)
                send_item(REQ_REF, idx, rand_coord(mode), rand_coord(mode),
                          rand_coord(mode), gaps);
            else if (r < 19)
                send_item(REQ_VOXEL, idx, rand_coord(mode), rand_coord(mode),
                          rand_coord(mode), gaps);
            else
                send_item(REQ_UNKNOWN, idx, $urandom, $urandom, $urandom, gaps);
        end
    endtask

    initial begin
        logic [4:0] counts [6];
        counts = '{5'd16, 5'd31, 5'd7, 5'd2, 5'd17, 5'd8};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // zero count: every point is inside
        send_item(REQ_VOXEL, 4'd0, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 1'b0);
        send_item(REQ_UNKNOWN, 4'd15, 32'hffff_ffff, 32'h0, 32'h8000_0000, 1'b0);
        // unit-ish box vertices into every slot, extremes included
        for (int i = 0; i < MAX_POINTS; i++)
            send_item(REQ_LOAD, i[3:0], (i[0] ? 32'h0001_0000 : 32'h0) + (i << 14),
                      (i[1] ? 32'h0001_0000 : 32'h0), (i[2] ? 32'h7fff_ffff : 32'h8000_0000),
                      1'b0);
        write_count(5'd16);
        send_item(REQ_REF, 4'd0, 32'h0, 32'h0, 32'h0, 1'b0);
        send_item(REQ_VOXEL, 4'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_item(REQ_VOXEL, 4'd0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
        // degenerate planes: all vertices equal
        for (int i = 0; i < 4; i++)
            send_item(REQ_LOAD, i[3:0], 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
        write_count(5'd4);
        send_item(REQ_VOXEL, 4'd0, 32'h0, 32'h0, 32'h0, 1'b0);
        write_count(5'd1);
        send_item(REQ_VOXEL, 4'd0, 32'hdead_beef, 32'h1234_5678, 32'h0, 1'b0);

        for (int ph = 0; ph < 6; ph++) begin
            write_count(counts[ph]);
            random_phase(200, 1'b1);
            if (ph == 2) drain();
        end
        write_count(5'd0);
        random_phase(60, 1'b1);
        write_count(5'd16);
        random_phase(40, 1'b0);

        drain();
        if (fail_count == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule
